FILE: rtl/ctt_pkg.sv
// Package with the shared constants, codes and types of the connection timeout table.
package ctt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int MAX_RESULTS = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam int MODE_W  = 2;
    localparam int ID_W    = 31;
    localparam int LIMIT_W = 16;
    localparam int TIME_W  = 32;
    localparam int KIND_W  = 3;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 32;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CHECK  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_INSERTED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVED  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EXPIRED  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NONE     = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [TIME_W-1:0]  created;
        logic [LIMIT_W-1:0] limit;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

FILE: rtl/ctt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module ctt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/connection_timeout_table.sv
// Connection table with insert, remove and idle-timeout expiry scan over one entry RAM.
// Valid items are scanned slot by slot, each slot by a RAM read state, then an evaluate state.
// Insert and remove stop their scan early on a matching id.
// Check scans every slot; every item also stalls while the output is full.
// Ignored items skip the scan. The entry RAM read port sets the per-slot pace.
// Reset clears the slot valid bits at once; the RAM contents are left as they are.
module connection_timeout_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: conn_id[30:0], timeout_ticks[46:31], now_time[78:47], zero pad [79]
    input  logic [ctt_pkg::IN_DATA_W-1:0]     s_tdata,
    // s_tuser: mode[1:0]
    input  logic [ctt_pkg::MODE_W-1:0]        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: result conn_id[30:0], zero pad [31]
    output logic [ctt_pkg::OUT_DATA_W-1:0]    m_tdata,
    // m_tuser: kind[2:0]
    output logic [ctt_pkg::KIND_W-1:0]        m_tuser,
    output logic                              m_tlast
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_EV   = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] r_state, n_state;

    logic [ctt_pkg::MODE_W-1:0]  r_op;
    logic                        r_ign;
    logic [ctt_pkg::ID_W-1:0]    r_id;
    logic [ctt_pkg::LIMIT_W-1:0] r_limit;
    logic [ctt_pkg::TIME_W-1:0]  r_now;

    logic [ctt_pkg::ADDR_W-1:0]  r_addr, n_addr;
    logic [ctt_pkg::TABLE_DEPTH-1:0] r_valid, n_valid;
    logic                        r_hit, n_hit;
    logic [ctt_pkg::ADDR_W-1:0]  r_hit_idx, n_hit_idx;
    logic                        r_pend, n_pend;
    logic [ctt_pkg::ID_W-1:0]    r_pend_id, n_pend_id;
    logic [ctt_pkg::CNT_W-1:0]   r_nres, n_nres;

    logic                        r_out_valid;
    logic [ctt_pkg::KIND_W-1:0]  r_out_kind;
    logic [ctt_pkg::ID_W-1:0]    r_out_id;
    logic                        r_out_last;

    logic                        push;
    logic [ctt_pkg::KIND_W-1:0]  push_kind;
    logic [ctt_pkg::ID_W-1:0]    push_id;
    logic                        push_last;

    logic                        ram_we;
    logic [ctt_pkg::ADDR_W-1:0]  ram_waddr;
    ctt_pkg::t_entry             ram_wdata;
    logic                        ram_re;
    logic [ctt_pkg::ENTRY_W-1:0] ram_rdata;
    ctt_pkg::t_entry             ent;

    logic                        accept;
    logic                        out_free;
    logic                        slot_v;
    logic                        match;
    logic                        expired;
    logic                        last_slot;
    logic [ctt_pkg::TIME_W-1:0]  age;
    logic                        free_found;
    logic [ctt_pkg::ADDR_W-1:0]  free_idx;
    logic [ctt_pkg::LIMIT_W-1:0] in_limit;
    logic [ctt_pkg::MODE_W-1:0]  in_mode;
    logic [ctt_pkg::ID_W-1:0]    in_id;

    ctt_ram #(
        .WIDTH (ctt_pkg::ENTRY_W),
        .DEPTH (ctt_pkg::TABLE_DEPTH)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign s_tready = (r_state == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !r_out_valid || m_tready;

    assign in_mode  = s_tuser;
    assign in_id    = s_tdata[30:0];
    assign in_limit = (s_tdata[46:31] == '0) ? ctt_pkg::LIMIT_W'(1) : s_tdata[46:31];

    assign ent       = ctt_pkg::t_entry'(ram_rdata);
    assign slot_v    = r_valid[r_addr];
    assign match     = slot_v && (ent.id == r_id);
    assign age       = r_now - ent.created;
    assign expired   = slot_v && (age > {{(ctt_pkg::TIME_W-ctt_pkg::LIMIT_W){1'b0}}, ent.limit});
    assign last_slot = (r_addr == ctt_pkg::ADDR_W'(ctt_pkg::TABLE_DEPTH - 1));
    assign ram_re    = (r_state == S_RD);

    // Lowest free slot, from the valid flops.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = ctt_pkg::TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_found = 1'b1;
                free_idx   = ctt_pkg::ADDR_W'(i);
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_valid   = r_valid;
        n_hit     = r_hit;
        n_hit_idx = r_hit_idx;
        n_pend    = r_pend;
        n_pend_id = r_pend_id;
        n_nres    = r_nres;
        push      = 1'b0;
        push_kind = ctt_pkg::KIND_NONE;
        push_id   = '0;
        push_last = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = free_idx;
        ram_wdata = '{id: r_id, created: r_now, limit: r_limit};

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_addr = '0;
                    n_hit  = 1'b0;
                    n_pend = 1'b0;
                    n_nres = '0;
                    if ((in_mode == ctt_pkg::MODE_CHECK)
                        || ((in_mode == ctt_pkg::MODE_INSERT
                             || in_mode == ctt_pkg::MODE_REMOVE) && in_id != '0)) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                if (r_op == ctt_pkg::MODE_CHECK) begin
                    // A new expiry first pushes the previous one out as a non-final result.
                    if (expired && r_pend && !out_free) begin
                        n_state = S_EV;
                    end else begin
                        if (expired) begin
                            if (r_pend) begin
                                push      = 1'b1;
                                push_kind = ctt_pkg::KIND_EXPIRED;
                                push_id   = r_pend_id;
                            end
                            n_pend            = 1'b1;
                            n_pend_id         = ent.id;
                            n_valid[r_addr]   = 1'b0;
                            n_nres            = r_nres + 1'b1;
                        end
                        if (last_slot || (expired
                            && r_nres == ctt_pkg::CNT_W'(ctt_pkg::MAX_RESULTS - 1))) begin
                            n_state = S_FIN;
                        end else begin
                            n_addr  = r_addr + 1'b1;
                            n_state = S_RD;
                        end
                    end
                end else begin
                    if (match) begin
                        n_hit     = 1'b1;
                        n_hit_idx = r_addr;
                        if (r_op == ctt_pkg::MODE_REMOVE) begin
                            n_valid[r_addr] = 1'b0;
                        end
                        n_state = S_FIN;
                    end else if (last_slot) begin
                        n_state = S_FIN;
                    end else begin
                        n_addr  = r_addr + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    n_state   = S_IDLE;
                    n_pend    = 1'b0;
                    if (r_ign) begin
                        push_kind = ctt_pkg::KIND_NONE;
                    end else if (r_op == ctt_pkg::MODE_INSERT) begin
                        push_id = r_id;
                        if (r_hit || free_found) begin
                            push_kind          = ctt_pkg::KIND_INSERTED;
                            ram_we             = 1'b1;
                            ram_waddr          = r_hit ? r_hit_idx : free_idx;
                            n_valid[ram_waddr] = 1'b1;
                        end else begin
                            push_kind = ctt_pkg::KIND_FULL;
                        end
                    end else if (r_op == ctt_pkg::MODE_REMOVE) begin
                        push_kind = ctt_pkg::KIND_REMOVED;
                        push_id   = r_id;
                    end else if (r_pend) begin
                        push_kind = ctt_pkg::KIND_EXPIRED;
                        push_id   = r_pend_id;
                    end else begin
                        push_kind = ctt_pkg::KIND_NONE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_pend      <= 1'b0;
            r_hit       <= 1'b0;
            r_nres      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_pend  <= n_pend;
            r_hit   <= n_hit;
            r_nres  <= n_nres;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_hit_idx <= n_hit_idx;
        r_pend_id <= n_pend_id;
        if (accept) begin
            r_op    <= in_mode;
            r_ign   <= !((in_mode == ctt_pkg::MODE_CHECK)
                         || ((in_mode == ctt_pkg::MODE_INSERT
                              || in_mode == ctt_pkg::MODE_REMOVE) && in_id != '0));
            r_id    <= in_id;
            r_limit <= in_limit;
            r_now   <= s_tdata[78:47];
        end
        if (push) begin
            r_out_kind <= push_kind;
            r_out_id   <= push_id;
            r_out_last <= push_last;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {1'b0, r_out_id};
    assign m_tuser  = r_out_kind;
    assign m_tlast  = r_out_last;

    a_ram_write_in_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_FIN && r_op == ctt_pkg::MODE_INSERT && !r_ign))
        else $error("entry RAM written outside the insert completion");

    a_pend_only_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_op == ctt_pkg::MODE_CHECK && r_state != S_IDLE))
        else $error("pending expiry outside a check scan");

    a_fin_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && out_free) |=> (r_state == S_IDLE && m_tvalid && m_tlast))
        else $error("final result not issued on completion");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= ctt_pkg::CNT_W'(ctt_pkg::MAX_RESULTS))
        else $error("expiry count above the result limit");

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the connection timeout table: driver, monitor and shadow table.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 7;
    localparam int RANDOM_OPS     = 250;
    localparam int ID_POOL_SIZE   = 48;
    localparam int QUIET_LIMIT    = 4000;
    localparam int TAIL_CYCLES    = 2 * ctt_pkg::TABLE_DEPTH + 10;
    localparam int REPORT_LIMIT   = 10;

    // Mode 3 has no function in the block; it must be ignored.
    localparam logic [ctt_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [ctt_pkg::MODE_W-1:0]  mode;
        logic [ctt_pkg::ID_W-1:0]    conn_id;
        logic [ctt_pkg::LIMIT_W-1:0] timeout_ticks;
        logic [ctt_pkg::TIME_W-1:0]  now_time;
        logic                        drain_first;
    } t_conn_op;

    typedef struct packed {
        logic [ctt_pkg::KIND_W-1:0] kind;
        logic [ctt_pkg::ID_W-1:0]   conn_id;
        logic                       last;
    } t_conn_result;

    logic                           i_clk    = 1'b0;
    logic                           i_rst_n  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [ctt_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
    logic [ctt_pkg::MODE_W-1:0]     s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [ctt_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [ctt_pkg::KIND_W-1:0]     m_tuser;
    logic                           m_tlast;

    t_conn_op     op_queue [$];
    t_conn_result due_results [$];
    t_conn_result want;

    // Shadow copy of the connection entries.
    logic                        slot_used  [ctt_pkg::TABLE_DEPTH];
    logic [ctt_pkg::ID_W-1:0]    slot_conn  [ctt_pkg::TABLE_DEPTH];
    logic [ctt_pkg::TIME_W-1:0]  slot_born  [ctt_pkg::TABLE_DEPTH];
    logic [ctt_pkg::LIMIT_W-1:0] slot_allow [ctt_pkg::TABLE_DEPTH];

    int planned_ops    = 0;
    int total_ops      = 0;
    int issued_ops     = 0;
    int taken_ops      = 0;
    int results_seen   = 0;
    int fail_count     = 0;
    int outstanding    = 0;
    int quiet_cycles   = 0;
    int send_idle_pct  = 18;
    int recv_stall_pct = 61;
    int kind_seen [5];

    connection_timeout_table dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic queue_item(input logic [ctt_pkg::MODE_W-1:0] mode,
                              input logic [ctt_pkg::ID_W-1:0] cid,
                              input logic [ctt_pkg::LIMIT_W-1:0] tmo,
                              input logic [ctt_pkg::TIME_W-1:0] tnow,
                              input logic drain);
        t_conn_op op;
        op.mode          = mode;
        op.conn_id       = cid;
        op.timeout_ticks = tmo;
        op.now_time      = tnow;
        op.drain_first   = drain;
        op_queue.push_back(op);
        if (mode == ctt_pkg::MODE_CHECK
            || ((mode == ctt_pkg::MODE_INSERT || mode == ctt_pkg::MODE_REMOVE)
                && cid != '0)) begin
            planned_ops++;
        end
    endtask

    function automatic logic [ctt_pkg::ID_W-1:0] fresh_id();
        logic [ctt_pkg::ID_W-1:0] v;
        v = ctt_pkg::ID_W'($urandom);
        if (v == '0) begin
            v = 31'd1;
        end
        return v;
    endfunction

    task automatic push_result(input logic [ctt_pkg::KIND_W-1:0] kind,
                               input logic [ctt_pkg::ID_W-1:0] cid,
                               input logic last);
        t_conn_result r;
        r.kind    = kind;
        r.conn_id = cid;
        r.last    = last;
        due_results.push_back(r);
    endtask

    // Applies one accepted item to the shadow entries and queues the results it must produce.
    task automatic apply_table_op(input logic [ctt_pkg::MODE_W-1:0] op,
                                  input logic [ctt_pkg::ID_W-1:0] cid,
                                  input logic [ctt_pkg::LIMIT_W-1:0] tmo,
                                  input logic [ctt_pkg::TIME_W-1:0] tnow);
        int slot;
        int hit_n;
        int emitted;
        int hits [ctt_pkg::TABLE_DEPTH];
        logic [ctt_pkg::TIME_W-1:0] age;
        slot    = -1;
        hit_n   = 0;
        emitted = 0;
        if (op == ctt_pkg::MODE_INSERT && cid != '0) begin
            for (int i = 0; i < ctt_pkg::TABLE_DEPTH; i++) begin
                if (slot < 0 && slot_used[i] && slot_conn[i] == cid) begin
                    slot = i;
                end
            end
            for (int i = 0; i < ctt_pkg::TABLE_DEPTH; i++) begin
                if (slot < 0 && !slot_used[i]) begin
                    slot = i;
                end
            end
            if (slot < 0) begin
                push_result(ctt_pkg::KIND_FULL, cid, 1'b1);
            end else begin
                slot_used[slot]  = 1'b1;
                slot_conn[slot]  = cid;
                slot_born[slot]  = tnow;
                slot_allow[slot] = (tmo == '0) ? 16'd1 : tmo;
                push_result(ctt_pkg::KIND_INSERTED, cid, 1'b1);
            end
            emitted = 1;
        end else if (op == ctt_pkg::MODE_REMOVE && cid != '0) begin
            for (int i = 0; i < ctt_pkg::TABLE_DEPTH; i++) begin
                if (slot < 0 && slot_used[i] && slot_conn[i] == cid) begin
                    slot = i;
                    slot_used[i] = 1'b0;
                end
            end
            push_result(ctt_pkg::KIND_REMOVED, cid, 1'b1);
            emitted = 1;
        end else if (op == ctt_pkg::MODE_CHECK) begin
            for (int i = 0; i < ctt_pkg::TABLE_DEPTH && hit_n < ctt_pkg::MAX_RESULTS; i++) begin
                if (slot_used[i]) begin
                    age = tnow - slot_born[i];
                    if (age > {16'd0, slot_allow[i]}) begin
                        hits[hit_n] = i;
                        hit_n++;
                        slot_used[i] = 1'b0;
                    end
                end
            end
            for (int k = 0; k < hit_n; k++) begin
                push_result(ctt_pkg::KIND_EXPIRED, slot_conn[hits[k]], k == hit_n - 1);
            end
            emitted = hit_n;
        end
        if (emitted == 0) begin
            push_result(ctt_pkg::KIND_NONE, '0, 1'b1);
        end
    endtask

    // Driver: holds an item until accepted; an item marked drain_first waits for all results.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end else begin
            if (!s_tvalid || s_tready) begin
                if (op_queue.size() > 0 && $urandom_range(99) >= send_idle_pct &&
                    (!op_queue[0].drain_first || (!s_tvalid && outstanding == 0))) begin
                    t_conn_op op;
                    op = op_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, op.now_time, op.timeout_ticks, op.conn_id};
                    s_tuser  <= op.mode;
                    issued_ops <= issued_ops + 1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            if (issued_ops < total_ops / 3) begin
                send_idle_pct  <= 18;
                recv_stall_pct <= 61;
            end else if (issued_ops < 2 * total_ops / 3) begin
                send_idle_pct  <= 61;
                recv_stall_pct <= 18;
            end else begin
                send_idle_pct  <= 0;
                recv_stall_pct <= 0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predicts on every accepted item, then checks every accepted result.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ctt_pkg::TABLE_DEPTH; i++) begin
                slot_used[i] = 1'b0;
            end
            outstanding  <= 0;
            quiet_cycles <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_table_op(s_tuser, s_tdata[30:0], s_tdata[46:31], s_tdata[78:47]);
                taken_ops++;
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (m_tuser <= ctt_pkg::KIND_NONE) begin
                    kind_seen[m_tuser]++;
                end
                if (due_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("%0t: unexpected result kind %0d id %h last %b",
                                 $time, m_tuser, m_tdata[30:0], m_tlast);
                    end
                end else begin
                    want = due_results.pop_front();
                    if (m_tuser !== want.kind || m_tdata[30:0] !== want.conn_id ||
                        m_tlast !== want.last) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display({"%0t: mismatch, expected kind %0d id %h last %b, ",
                                      "got kind %0d id %h last %b"},
                                     $time, want.kind, want.conn_id, want.last,
                                     m_tuser, m_tdata[30:0], m_tlast);
                        end
                    end
                end
            end
            outstanding  <= due_results.size();
            quiet_cycles <= ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                            ? 0 : quiet_cycles + 1;
        end
    end

    initial begin
        do @(posedge i_clk); while (quiet_cycles < QUIET_LIMIT);
        $display("No item moved on either side for %0d cycles.", QUIET_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial begin
        logic [ctt_pkg::TIME_W-1:0]  clk_now;
        logic [ctt_pkg::ID_W-1:0]    id_pool [ID_POOL_SIZE];
        logic [ctt_pkg::ID_W-1:0]    cid;
        logic [ctt_pkg::LIMIT_W-1:0] tmo;
        logic [ctt_pkg::TIME_W-1:0]  tnow;
        int n;
        int pick;
        bit first_burst;

        for (int k = 0; k < 5; k++) begin
            kind_seen[k] = 0;
        end

        // Directed items: ignored items, extremes, replacement, slot order and wraparound age.
        queue_item(ctt_pkg::MODE_CHECK,  31'd0,         16'd0,    32'd0,         1'b0);
        queue_item(ctt_pkg::MODE_INSERT, 31'd0,         16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        queue_item(ctt_pkg::MODE_REMOVE, 31'd0,         16'd0,    32'd0,         1'b0);
        queue_item(MODE_SPARE,           31'h7FFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        queue_item(MODE_SPARE,           31'd0,         16'd0,    32'd0,         1'b0);
        queue_item(ctt_pkg::MODE_INSERT, 31'h7FFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        queue_item(ctt_pkg::MODE_INSERT, 31'd1,         16'd0,    32'hFFFF_FFF0, 1'b0);
        queue_item(ctt_pkg::MODE_INSERT, 31'h2AAA_AAAA, 16'h1234, 32'd0,         1'b0);
        queue_item(ctt_pkg::MODE_INSERT, 31'd1,         16'd5,    32'hFFFF_FFFE, 1'b0);
        queue_item(ctt_pkg::MODE_REMOVE, 31'd12345,     16'd0,    32'd0,         1'b0);
        queue_item(ctt_pkg::MODE_CHECK,  31'h5555_5555, 16'hAAAA, 32'd0,         1'b1);
        queue_item(ctt_pkg::MODE_CHECK,  31'd0,         16'd0,    32'd3,         1'b0);
        queue_item(ctt_pkg::MODE_CHECK,  31'd0,         16'd0,    32'd4,         1'b0);
        queue_item(ctt_pkg::MODE_INSERT, 31'h5555_5555, 16'd0,    32'd100,       1'b0);
        queue_item(ctt_pkg::MODE_CHECK,  31'd0,         16'd0,    32'd101,       1'b0);
        queue_item(ctt_pkg::MODE_CHECK,  31'd0,         16'd0,    32'd102,       1'b0);
        queue_item(ctt_pkg::MODE_REMOVE, 31'h7FFF_FFFF, 16'd0,    32'd0,         1'b0);
        queue_item(ctt_pkg::MODE_REMOVE, 31'h7FFF_FFFF, 16'd0,    32'd0,         1'b0);
        queue_item(ctt_pkg::MODE_INSERT, 31'd2,         16'hFFFF, 32'd0,         1'b0);
        queue_item(ctt_pkg::MODE_CHECK,  31'd0,         16'd0,    32'hFFFF_FFFF, 1'b0);

        // Random part: bursts that can overflow the table, and mixed traffic on a shared id pool.
        planned_ops = 0;
        clk_now = 32'hFFFF_F000;
        for (int k = 0; k < ID_POOL_SIZE; k++) begin
            id_pool[k] = fresh_id();
        end
        id_pool[0] = 31'h7FFF_FFFF;
        first_burst = 1'b1;
        while (planned_ops < RANDOM_OPS) begin
            if (first_burst || $urandom_range(9) == 0) begin
                n = $urandom_range(30, 36);
                for (int k = 0; k < n; k++) begin
                    queue_item(ctt_pkg::MODE_INSERT, fresh_id(), ctt_pkg::LIMIT_W'($urandom),
                               clk_now + $urandom_range(0, 20), 1'b0);
                end
                if (first_burst || $urandom_range(1) == 1) begin
                    tnow = clk_now + 32'h8000_0000;
                end else begin
                    tnow = clk_now + $urandom_range(0, 70000);
                end
                queue_item(ctt_pkg::MODE_CHECK, ctt_pkg::ID_W'($urandom),
                           ctt_pkg::LIMIT_W'($urandom), tnow, $urandom_range(3) == 0);
                first_burst = 1'b0;
            end else begin
                n = $urandom_range(8, 16);
                for (int k = 0; k < n; k++) begin
                    clk_now = clk_now + $urandom_range(0, 40);
                    pick = $urandom_range(99);
                    cid = id_pool[$urandom_range(ID_POOL_SIZE - 1)];
                    if (pick < 45) begin
                        case ($urandom_range(7))
                            0: tmo = '0;
                            1: tmo = ctt_pkg::LIMIT_W'($urandom);
                            default: tmo = ctt_pkg::LIMIT_W'($urandom_range(1, 300));
                        endcase
                        tnow = ($urandom_range(9) == 0) ? $urandom : clk_now;
                        queue_item(ctt_pkg::MODE_INSERT, cid, tmo, tnow, 1'b0);
                    end else if (pick < 65) begin
                        queue_item(ctt_pkg::MODE_REMOVE,
                                   ($urandom_range(4) == 0) ? fresh_id() : cid,
                                   ctt_pkg::LIMIT_W'($urandom), $urandom, 1'b0);
                    end else if (pick < 90) begin
                        tnow = ($urandom_range(9) == 0) ? $urandom
                                                        : clk_now + $urandom_range(0, 300);
                        queue_item(ctt_pkg::MODE_CHECK, ctt_pkg::ID_W'($urandom),
                                   ctt_pkg::LIMIT_W'($urandom), tnow,
                                   $urandom_range(15) == 0);
                    end else begin
                        case ($urandom_range(2))
                            0: queue_item(MODE_SPARE, ctt_pkg::ID_W'($urandom),
                                          ctt_pkg::LIMIT_W'($urandom), $urandom, 1'b0);
                            1: queue_item(ctt_pkg::MODE_INSERT, '0,
                                          ctt_pkg::LIMIT_W'($urandom), $urandom, 1'b0);
                            default: queue_item(ctt_pkg::MODE_REMOVE, '0,
                                                ctt_pkg::LIMIT_W'($urandom), $urandom, 1'b0);
                        endcase
                    end
                end
            end
        end
        total_ops = op_queue.size();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk); while (op_queue.size() != 0 || s_tvalid);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d items and %0d results under three handshake pacing phases.",
                 taken_ops, results_seen);
        $display({"Results by kind: inserted %0d, dropped on full %0d, removed %0d, ",
                  "expired %0d, none %0d."},
                 kind_seen[ctt_pkg::KIND_INSERTED], kind_seen[ctt_pkg::KIND_FULL],
                 kind_seen[ctt_pkg::KIND_REMOVED], kind_seen[ctt_pkg::KIND_EXPIRED],
                 kind_seen[ctt_pkg::KIND_NONE]);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/ctt_pkg.sv
rtl/ctt_ram.sv
rtl/connection_timeout_table.sv
sim/tb_top.sv
